// ===== rtl/core/first_free_slot_table_top_assert.svh =====
// Assertion macros shared by the first free slot table RTL.
// Expects clk and the active-low rst_n in the scope where a macro is used.
`ifndef FIRST_FREE_SLOT_TABLE_TOP_ASSERT_SVH
`define FIRST_FREE_SLOT_TABLE_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define FFST_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("first free slot table: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define FFST_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("first free slot table: next-cycle check failed");

`endif

// ===== rtl/core/ffst_pkg.sv =====
// Shared types, operation codes and widths of the first free slot table.
// No dependencies; every other file of the block but the RAM and the assertion header imports it.
package ffst_pkg;

    localparam int SLOTS_DEFAULT      = 256;
    localparam int VALUE_BITS_DEFAULT = 32;

    // The occupancy search works on chunks of this many slots.
    localparam int CHUNK_BITS     = 32;
    localparam int CHUNK_IDX_BITS = 5;

    localparam int OP_BITS         = 3;
    localparam int INDEX_BITS      = 8;
    localparam int PORT_VALUE_BITS = 32;
    localparam int COUNT_BITS      = 9;
    localparam int S_TDATA_BITS    = 40;
    localparam int M_TDATA_BITS    = 64;
    localparam int M_TDATA_USED    = INDEX_BITS + PORT_VALUE_BITS + 2 * COUNT_BITS;

    localparam logic [OP_BITS-1:0] OP_SET_FIRST = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SET_AT    = 3'd1;
    localparam logic [OP_BITS-1:0] OP_LOOKUP    = 3'd2;
    localparam logic [OP_BITS-1:0] OP_RAW       = 3'd3;
    localparam logic [OP_BITS-1:0] OP_UNSET     = 3'd4;
    localparam logic [OP_BITS-1:0] OP_COUNT     = 3'd5;

    typedef struct packed {
        logic accept;
        logic chunk_step;
        logic bit_step;
        logic exec;
        logic trim;
    } ffst_cmd_t;

    typedef struct packed {
        logic [OP_BITS-1:0] in_op;
        logic [OP_BITS-1:0] op;
        logic               lower;
        logic               out_free;
    } ffst_stat_t;

endpackage

// ===== rtl/core/ffst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ffst_search.sv =====
// Two-step occupancy search: first the chunk, then the slot inside the chunk.
// Depends on ffst_pkg for the chunk size.
module ffst_search #(
    parameter int SLOTS = ffst_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [SLOTS-1:0]         occ,
    input  logic                     find_last,
    input  logic                     chunk_step,
    input  logic                     bit_step,
    output logic                     found,
    output logic [$clog2(SLOTS)-1:0] pos
);
    import ffst_pkg::*;

    localparam int IDXW = $clog2(SLOTS);
    localparam int CW   = CHUNK_BITS;
    localparam int CIW  = CHUNK_IDX_BITS;
    localparam int NCH  = (SLOTS + CW - 1) / CW;
    localparam int NCHW = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PADW = NCH * CW;

    logic [PADW-1:0] tgt_c;
    logic [NCH-1:0]  flag_c;
    logic [NCHW-1:0] chunk_c;
    logic [CW-1:0]   word_c;
    logic [CIW-1:0]  bit_c;
    logic [NCHW-1:0] chunk_reg;
    logic            cfound_reg;
    logic [NCHW+CIW-1:0] pos_reg;
    logic            found_reg;

    // Free search looks for the lowest empty slot, trim search for the highest
    // occupied one; both become a search for a set bit, padding reads as zero.
    assign tgt_c = find_last ? PADW'(occ) : PADW'(~occ);

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            flag_c[c] = |tgt_c[c*CW +: CW];
        end
    end

    // The last assignment wins: ascending order keeps the highest hit,
    // descending order the lowest.
    always_comb
    begin
        int j;
        chunk_c = '0;
        for (int i = 0; i < NCH; i++)
        begin
            j = find_last ? i : (NCH - 1 - i);
            if (flag_c[j])
            begin
                chunk_c = NCHW'(j);
            end
        end
    end

    assign word_c = tgt_c[chunk_reg*CW +: CW];

    always_comb
    begin
        int j;
        bit_c = '0;
        for (int i = 0; i < CW; i++)
        begin
            j = find_last ? i : (CW - 1 - i);
            if (word_c[j])
            begin
                bit_c = CIW'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfound_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (chunk_step)
            begin
                cfound_reg <= |flag_c;
            end
            if (bit_step)
            begin
                found_reg <= cfound_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chunk_step)
        begin
            chunk_reg <= chunk_c;
        end
        if (bit_step)
        begin
            pos_reg <= {chunk_reg, bit_c};
        end
    end

    assign found = found_reg;
    assign pos   = IDXW'(pos_reg);

endmodule

// ===== rtl/core/ffst_datapath.sv =====
// Datapath: slot RAM, occupancy bitmap, high-water mark, count and result register.
// Depends on ffst_pkg, ffst_ram, ffst_search and the assertion macro header.
`include "first_free_slot_table_top_assert.svh"

module ffst_datapath #(
    parameter int SLOTS      = ffst_pkg::SLOTS_DEFAULT,
    parameter int VALUE_BITS = ffst_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ffst_pkg::ffst_cmd_t               cmd,
    output ffst_pkg::ffst_stat_t              stat,
    input  logic [ffst_pkg::OP_BITS-1:0]      s_tuser,
    input  logic [ffst_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffst_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                              m_tuser
);
    import ffst_pkg::*;

    localparam int IDXW = $clog2(SLOTS);
    localparam int MW   = $clog2(SLOTS + 1);

    logic [OP_BITS-1:0]    op_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [VALUE_BITS-1:0] val_reg;

    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [MW-1:0]    mark_reg, mark_next;
    logic [MW-1:0]    count_reg, count_next;

    logic [INDEX_BITS-1:0]      placed_reg;
    logic [PORT_VALUE_BITS-1:0] readv_reg;
    logic [COUNT_BITS-1:0]      cnt_out_reg;
    logic [COUNT_BITS-1:0]      mark_out_reg;
    logic                       status_reg;
    logic                       m_tvalid_reg;

    logic [VALUE_BITS-1:0] rdata;
    logic                  srch_found;
    logic [IDXW-1:0]       srch_pos;

    logic [IDXW-1:0]       slot_a;
    logic                  in_range, below_mark, top_hit, occ_at_idx, lower_c, new_nz;
    logic                  wr_en, load_c, status_c;
    logic [IDXW-1:0]       wr_addr;
    logic [INDEX_BITS-1:0] placed_c;
    logic [VALUE_BITS-1:0] readv_c;
    logic [MW-1:0]         cnt_c;

    ffst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (val_reg),
        .re    (cmd.accept),
        .raddr (IDXW'(s_tdata[INDEX_BITS-1:0])),
        .rdata (rdata)
    );

    ffst_search #(
        .SLOTS (SLOTS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .occ        (occ_reg),
        .find_last  (op_reg == OP_UNSET),
        .chunk_step (cmd.chunk_step),
        .bit_step   (cmd.bit_step),
        .found      (srch_found),
        .pos        (srch_pos)
    );

    assign slot_a     = IDXW'(idx_reg);
    assign in_range   = int'(idx_reg) < SLOTS;
    assign below_mark = int'(idx_reg) < int'(mark_reg);
    assign top_hit    = (int'(idx_reg) + 1) == int'(mark_reg);
    assign occ_at_idx = in_range ? occ_reg[slot_a] : 1'b0;
    assign lower_c    = (op_reg == OP_UNSET) && in_range && top_hit;
    assign new_nz     = |val_reg;

    // A slot whose bitmap bit is clear reads as zero, so the RAM never needs
    // clearing; clearing a slot only touches the bitmap.
    always_comb
    begin
        occ_next   = occ_reg;
        mark_next  = mark_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_a;
        placed_c   = idx_reg;
        readv_c    = '0;
        cnt_c      = '0;
        status_c   = 1'b0;
        load_c     = 1'b0;
        if (cmd.exec)
        begin
            load_c = !lower_c;
            case (op_reg)
                OP_SET_FIRST:
                begin
                    if (srch_found)
                    begin
                        wr_en              = 1'b1;
                        wr_addr            = srch_pos;
                        occ_next[srch_pos] = new_nz;
                        count_next         = count_reg + MW'(new_nz);
                        if (mark_reg <= MW'(srch_pos))
                        begin
                            mark_next = MW'(srch_pos) + MW'(1);
                        end
                        placed_c = INDEX_BITS'(srch_pos);
                    end
                    else
                    begin
                        placed_c = '0;
                        status_c = 1'b1;
                    end
                end
                OP_SET_AT:
                begin
                    if (in_range)
                    begin
                        wr_en            = 1'b1;
                        occ_next[slot_a] = new_nz;
                        count_next       = count_reg - MW'(occ_at_idx) + MW'(new_nz);
                        if (mark_reg <= MW'(slot_a))
                        begin
                            mark_next = MW'(slot_a) + MW'(1);
                        end
                    end
                    else
                    begin
                        status_c = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (below_mark && occ_at_idx)
                    begin
                        readv_c = rdata;
                    end
                end
                OP_RAW:
                begin
                    if (!in_range)
                    begin
                        status_c = 1'b1;
                    end
                    else if (occ_at_idx)
                    begin
                        readv_c = rdata;
                    end
                end
                OP_UNSET:
                begin
                    if (in_range)
                    begin
                        occ_next[slot_a] = 1'b0;
                        count_next       = count_reg - MW'(occ_at_idx);
                    end
                    else
                    begin
                        status_c = 1'b1;
                    end
                end
                OP_COUNT:
                begin
                    cnt_c = count_reg;
                end
                default:
                begin
                end
            endcase
        end
        // Clearing the top slot: the mark drops to one past the highest
        // occupied slot that is left.
        if (cmd.trim)
        begin
            load_c    = 1'b1;
            mark_next = srch_found ? (MW'(srch_pos) + MW'(1)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            mark_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            mark_reg  <= mark_next;
            count_reg <= count_next;
            if (load_c)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= s_tuser;
            idx_reg <= s_tdata[INDEX_BITS-1:0];
            val_reg <= VALUE_BITS'(s_tdata[INDEX_BITS +: PORT_VALUE_BITS]);
        end
        if (load_c)
        begin
            placed_reg   <= placed_c;
            readv_reg    <= PORT_VALUE_BITS'(readv_c);
            cnt_out_reg  <= COUNT_BITS'(cnt_c);
            mark_out_reg <= COUNT_BITS'(mark_next);
            status_reg   <= status_c;
        end
    end

    assign stat.in_op    = s_tuser;
    assign stat.op       = op_reg;
    assign stat.lower    = lower_c;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_BITS - M_TDATA_USED)'(0), mark_out_reg, cnt_out_reg,
                       readv_reg, placed_reg};
    assign m_tuser  = status_reg;

    `FFST_ASSERT_SAME(a_count_within_mark, 1'b1, count_reg <= mark_reg)
    `FFST_ASSERT_SAME(a_mark_within_slots, 1'b1, int'(mark_reg) <= SLOTS)
    `FFST_ASSERT_SAME(a_slot_at_mark_empty, int'(mark_reg) < SLOTS, !occ_reg[IDXW'(mark_reg)])

endmodule

// ===== rtl/core/ffst_ctrl.sv =====
// Controller state machine: sequences accept, search, execute and mark trim.
// Depends on ffst_pkg and the assertion macro header.
`include "first_free_slot_table_top_assert.svh"

module ffst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output ffst_pkg::ffst_cmd_t  cmd,
    input  ffst_pkg::ffst_stat_t stat
);
    import ffst_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHUNK = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_TRIM  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = (stat.in_op == OP_SET_FIRST) ? S_CHUNK : S_EXEC;
                end
            end
            S_CHUNK:
            begin
                cmd.chunk_step = 1'b1;
                state_next     = S_BIT;
            end
            S_BIT:
            begin
                cmd.bit_step = 1'b1;
                state_next   = (stat.op == OP_UNSET) ? S_TRIM : S_EXEC;
            end
            S_EXEC:
            begin
                // Clearing the top slot produces no result yet; the mark search follows.
                if (stat.lower)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_CHUNK;
                end
                else if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TRIM:
            begin
                if (stat.out_free)
                begin
                    cmd.trim   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    `FFST_ASSERT_SAME(a_trim_only_on_unset, state_reg == S_TRIM, stat.op == OP_UNSET)
    `FFST_ASSERT_NEXT(a_chunk_then_bit, state_reg == S_CHUNK, state_reg == S_BIT)
    `FFST_ASSERT_NEXT(a_set_first_searches, cmd.accept && stat.in_op == OP_SET_FIRST,
        state_reg == S_CHUNK)

endmodule

// ===== rtl/core/first_free_slot_table_top.sv =====
// Top level of the first free slot table: controller plus datapath.
// Depends on ffst_pkg, ffst_ctrl and ffst_datapath.
//
// Usage: one operation enters on the s_* stream (s_tuser is the op code) and
// exactly one result leaves on the m_* stream (m_tuser is the status flag).
// The block works on one transaction at a time. Steps from accept to the
// result register, by operation:
//   set at index, lookup, raw lookup, count, unused codes: execute
//   set first free: chunk search, bit search, execute
//   unset of the top slot: execute, then chunk search, bit search, mark trim
//   unset elsewhere: execute
// s_tready is high only while the controller is idle. A finished result waits
// in the output register, and the next transaction is accepted meanwhile; if
// the receiver still stalls when that one finishes, the block holds it until
// the register frees. Reset clears the occupancy bitmap, the count and the
// mark; a slot with its bitmap bit clear reads as zero, so the slot RAM
// needs no clearing pass and the block is ready right after reset.
module first_free_slot_table_top #(
    parameter int SLOTS      = ffst_pkg::SLOTS_DEFAULT,
    parameter int VALUE_BITS = ffst_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] slot_index, [39:8] slot_value
    input  logic [ffst_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [2:0] op
    input  logic [ffst_pkg::OP_BITS-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] placed_index, [39:8] read_value, [48:40] occupied_count,
    // [57:49] mark_after, [63:58] zero
    output logic [ffst_pkg::M_TDATA_BITS-1:0] m_tdata,
    // [0] status
    output logic                              m_tuser
);
    import ffst_pkg::*;

    ffst_cmd_t  cmd;
    ffst_stat_t stat;

    ffst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ffst_datapath #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== dv/first_free_slot_table_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_free_slot_table_top: directed rows, then random
// operation sequences, scored against a behavioral model of the slot table or fixed results.
// Depends on ffst_pkg and the block's RTL only.
module first_free_slot_table_top_tb;
    import ffst_pkg::*;

    localparam int SLOTS_N        = 256;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;
    localparam int REPORT_MAX     = 10;

    // Codes the block treats as no-ops.
    localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;

    // Laid out to match {m_tuser, m_tdata}.
    typedef struct packed {
        logic       status;
        logic [5:0] pad;
        logic [8:0] mark;
        logic [8:0] count;
        logic [31:0] rdval;
        logic [7:0] placed;
    } slot_result_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic [7:0]         idx;
        logic [31:0]        val;
        bit                 typed;
        slot_result_t       res;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;   // [7:0] slot_index, [39:8] slot_value
    logic [OP_BITS-1:0]      s_tuser;   // [2:0] op
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;   // [7:0] placed, [39:8] read, [48:40] count, [57:49] mark
    logic                    m_tuser;   // [0] status

    // Model state of the table.
    logic [31:0]  slot_mem [SLOTS_N];
    int           water;

    slot_result_t result_q [$];
    dir_row_t     dir_rows [$];
    int           fail_count;
    int           src_idle_pct;
    int           sink_idle_pct;
    int           hold_asked;
    int           hold_served;
    int           stuck;

    first_free_slot_table_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Applies one operation to the model table and returns the result it produces.
    function automatic slot_result_t apply_op(input logic [OP_BITS-1:0] op,
                                              input logic [7:0] idx, input logic [31:0] val);
        slot_result_t r;
        int k;
        r = '0;
        r.placed = idx;
        case (op)
            OP_SET_FIRST:
            begin
                k = 0;
                while (k < water && slot_mem[k] != 32'd0)
                    k++;
                if (k >= SLOTS_N)
                begin
                    r.placed = 8'd0;
                    r.status = 1'b1;
                end
                else
                begin
                    slot_mem[k] = val;
                    if (water <= k)
                        water = k + 1;
                    r.placed = k[7:0];
                end
            end
            OP_SET_AT:
            begin
                slot_mem[idx] = val;
                if (water <= int'(idx))
                    water = int'(idx) + 1;
            end
            OP_LOOKUP:
                if (int'(idx) < water)
                    r.rdval = slot_mem[idx];
            OP_RAW:
                r.rdval = slot_mem[idx];
            OP_UNSET:
            begin
                slot_mem[idx] = 32'd0;
                // Clearing the top slot walks the mark down past trailing empties.
                if (int'(idx) + 1 == water)
                    while (water > 0 && slot_mem[water-1] == 32'd0)
                        water--;
            end
            OP_COUNT:
                for (k = 0; k < water; k++)
                    if (slot_mem[k] != 32'd0)
                        r.count++;
            default: ;
        endcase
        r.mark = water[8:0];
        return r;
    endfunction

    function automatic slot_result_t mk_res(input int placed, input logic [31:0] rdval,
                                            input int count, input int mark, input bit status);
        slot_result_t r;
        r        = '0;
        r.placed = placed[7:0];
        r.rdval  = rdval;
        r.count  = count[8:0];
        r.mark   = mark[8:0];
        r.status = status;
        return r;
    endfunction

    function automatic void add_row(input logic [OP_BITS-1:0] op, input logic [7:0] idx,
                                    input logic [31:0] val, input bit typed,
                                    input slot_result_t res);
        dir_row_t row;
        row.op    = op;
        row.idx   = idx;
        row.val   = val;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return 32'd0;
        if (sel == 1)
            return 32'hFFFF_FFFF;
        if (sel == 2)
            return 32'd1;
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_index();
        int hi;
        if (water > 0 && $urandom_range(0, 3) != 0)
        begin
            hi = water - 1;
            return 8'($urandom_range(0, hi));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one transaction, holds it until accepted, then records its expected result.
    task automatic push_op(input logic [OP_BITS-1:0] op, input logic [7:0] idx,
                           input logic [31:0] val, input bit typed,
                           input slot_result_t typed_res);
        slot_result_t pred;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = apply_op(op, idx, val);
        result_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    // Random sequences of one flavor each: fill runs, top-down clears, scattered writes and clears,
    // reads, counts, mixed valid operations, and a share of fully random noise.
    task automatic run_random(input int n_items);
        int done;
        int kind;
        int len;
        int i;
        int k;
        int filled;
        logic [OP_BITS-1:0] op;
        logic [7:0] idx;
        logic [31:0] val;
        done = 0;
        while (done < n_items)
        begin
            kind = $urandom_range(0, 19);
            len  = $urandom_range(1, 24);
            if (kind == 0)
            begin
                // Fill every empty slot, then run into the full table a few times.
                filled = 0;
                for (k = 0; k < water; k++)
                    if (slot_mem[k] != 32'd0)
                        filled++;
                len = SLOTS_N - filled + $urandom_range(1, 4);
            end
            for (i = 0; i < len; i++)
            begin
                idx = pick_index();
                val = pick_value();
                case (kind)
                    0:
                    begin
                        op = OP_SET_FIRST;
                        if (val == 32'd0)
                            val = 32'd1;
                    end
                    1, 2, 3:
                        op = OP_SET_FIRST;
                    4, 5:
                        op = OP_SET_AT;
                    6, 7:
                    begin
                        op  = OP_UNSET;
                        idx = (water > 0) ? 8'(water - 1) : 8'd0;
                    end
                    8, 9:
                        op = OP_UNSET;
                    10, 11:
                        op = ($urandom_range(0, 1) != 0) ? OP_LOOKUP : OP_RAW;
                    12:
                        op = OP_COUNT;
                    13, 14, 15, 16, 17:
                        op = OP_BITS'($urandom_range(0, 5));
                    default:
                    begin
                        op  = OP_BITS'($urandom_range(0, 7));
                        idx = 8'($urandom_range(0, 255));
                        val = $urandom;
                    end
                endcase
                push_op(op, idx, val, 1'b0, '0);
                if (op <= OP_COUNT)
                    done++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left   = 0;
        hold_served = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Scoreboard: every result transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin
        slot_result_t got;
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            if (result_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result transaction: %h", got);
            end
            else
            begin
                want = result_q.pop_front();
                if (got.placed !== want.placed || got.rdval !== want.rdval ||
                    got.count !== want.count || got.mark !== want.mark ||
                    got.pad !== want.pad || got.status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: expected idx=%0d val=%h cnt=%0d mark=%0d pad=%h st=%0d, got idx=%0d val=%h cnt=%0d mark=%0d pad=%h st=%0d",
                                 want.placed, want.rdval, want.count, want.mark, want.pad,
                                 want.status, got.placed, got.rdval, got.count, got.mark,
                                 got.pad, got.status);
                end
            end
        end
    end

    // Watchdog on cycles where no transaction moves on either side.
    initial
    begin
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int i;
        int k;
        fail_count    = 0;
        hold_asked    = 0;
        src_idle_pct  = 10;
        sink_idle_pct = 79;
        water         = 0;
        for (k = 0; k < SLOTS_N; k++)
            slot_mem[k] = 32'd0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_SET_FIRST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; the first ones start from an empty table.
        add_row(OP_COUNT,     8'd0,   32'd0,         1'b1, mk_res(0, 32'd0, 0, 0, 1'b0));
        add_row(OP_LOOKUP,    8'd0,   32'd0,         1'b1, mk_res(0, 32'd0, 0, 0, 1'b0));
        add_row(OP_RAW,       8'd255, 32'd0,         1'b1, mk_res(255, 32'd0, 0, 0, 1'b0));
        add_row(OP_SET_FIRST, 8'h33,  32'hFFFF_FFFF, 1'b1, mk_res(0, 32'd0, 0, 1, 1'b0));
        add_row(OP_SET_AT,    8'd255, 32'd1,         1'b1, mk_res(255, 32'd0, 0, 256, 1'b0));
        add_row(OP_LOOKUP,    8'd255, 32'd0,         1'b0, '0);
        add_row(OP_RAW,       8'd128, 32'd0,         1'b0, '0);
        add_row(OP_LOOKUP,    8'd0,   32'd0,         1'b0, '0);
        // A stored zero still counts as an empty slot for the next search.
        add_row(OP_SET_FIRST, 8'd0,   32'd0,         1'b0, '0);
        add_row(OP_SET_FIRST, 8'd7,   32'hA5A5_A5A5, 1'b0, '0);
        add_row(OP_COUNT,     8'd9,   32'd0,         1'b0, '0);
        add_row(OP_UNSET,     8'd128, 32'd0,         1'b0, '0);
        add_row(OP_UNSET,     8'd255, 32'd0,         1'b0, '0);
        add_row(OP_LOOKUP,    8'd200, 32'd0,         1'b0, '0);
        add_row(OP_RAW,       8'd255, 32'd0,         1'b0, '0);
        add_row(OP_SPARE_A,   8'h5A,  32'h1234_5678, 1'b0, '0);
        add_row(OP_SPARE_B,   8'hFF,  32'hFFFF_FFFF, 1'b0, '0);
        add_row(OP_UNSET,     8'd200, 32'd0,         1'b0, '0);
        add_row(OP_SET_AT,    8'd0,   32'd0,         1'b0, '0);
        add_row(OP_UNSET,     8'd1,   32'd0,         1'b0, '0);
        add_row(OP_COUNT,     8'd0,   32'd0,         1'b0, '0);
        add_row(OP_SET_FIRST, 8'd0,   32'h8000_0000, 1'b0, '0);
        add_row(OP_RAW,       8'd0,   32'd0,         1'b0, '0);
        for (i = 0; i < dir_rows.size(); i++)
            push_op(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                    dir_rows[i].typed, dir_rows[i].res);

        run_random(250);
        // Long receiver hold-off while the sender keeps offering transactions.
        hold_asked++;
        run_random(250);
        drain_results();

        src_idle_pct  = 79;
        sink_idle_pct = 10;
        run_random(500);
        drain_results();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(500);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
